// File: rtl/lpp_pkg.sv
package lpp_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 16;
   localparam int MODE_W    = 4;
   localparam int CMP_W     = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int PIX_W     = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_MEAN3    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_LEFT     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_ABOVE    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_UPLEFT   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_PLANAR   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_HALF_BC  = 4'd5;
   localparam logic [MODE_W-1:0] MODE_HALF_AC  = 4'd6;
   localparam logic [MODE_W-1:0] MODE_MEAN2    = 4'd7;
   localparam logic [MODE_W-1:0] MODE_MED      = 4'd8;

   localparam logic [19:0] RECIP3    = 20'd683;
   localparam int          RECIP3_SH = 11;

   typedef enum logic [1:0] {
      POS_FIRST,
      POS_FIRST_ROW,
      POS_FIRST_COL,
      POS_INTERIOR
   } pos_type;

   typedef struct packed {
      pos_type             pos;
      logic [MODE_W-1:0]   mode;
   } lane_ctl_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] blue_diff;
      logic [7:0] red_diff;
      logic       row_end;
      logic       image_end;
   } out_item_type;

endpackage

// File: rtl/lossless_pixel_prediction_reconstruct.sv
// Lossless predictive pixel reconstruction, three 8-bit channels.
// Input channel (req_*): one residual transaction per pixel in raster order,
// accepted on a rising edge with req_valid high and req_stall low.
// Output channel (rsp_*): one rebuilt pixel per input, with row_end and
// image_end flags, taken on a rising edge with rsp_valid high and
// rsp_stall low.
// Configuration (csr_*): write prediction_mode (index 0), image_width
// (index 1) and image_height (index 2) with csr_wr_en; no read-back.
// An accepted pixel goes to the output register, or to the skid register
// if a stalled pixel holds it. One pixel per clock while req_stall is low,
// set by the left-pixel register loop through the three prediction lanes.
// The previous row sits in a 1024-entry line memory read one pixel ahead;
// a write-to-read bypass covers very narrow images.
// When the receiver stalls, the output register holds its transaction and a
// skid register takes one more; req_stall rises only once the skid is full.
// Synchronous reset clears the counters and neighbor registers, empties the
// output stages and loads mode 0, width 1024, height 1. The line memory is
// not cleared; the first row never reads it.
module lossless_pixel_prediction_reconstruct
   import lpp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [8:0]    req_residual_luma,
   input  logic signed [8:0]    req_residual_blue_diff,
   input  logic signed [8:0]    req_residual_red_diff,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_pixel_luma,
   output logic [7:0]           rsp_pixel_blue_diff,
   output logic [7:0]           rsp_pixel_red_diff,
   output logic                 rsp_row_end,
   output logic                 rsp_image_end,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   logic [MODE_W-1:0]   mode_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [COL_W-1:0]    col_ff, col_in, rd_addr;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0]    left_ff, upl_ff, above, pixel;
   logic [CMP_W-1:0]    width_ext, width_eff, last_col;
   logic [HEIGHT_W-1:0] height_eff, last_row;
   logic                acc, row_last, image_last;
   lane_ctl_type        ctl;
   out_item_type        item;

   assign acc = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_MEAN3;
         width_ff  <= WIDTH_W'(MAX_WIDTH);
         height_ff <= HEIGHT_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign width_ext  = CMP_W'(width_ff);
   assign width_eff  = (width_ff == '0) ? CMP_W'(1) :
                       (width_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_ext;
   assign last_col   = width_eff - CMP_W'(1);
   assign height_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
   assign last_row   = height_eff - HEIGHT_W'(1);

   assign row_last   = CMP_W'(col_ff) >= last_col;
   assign image_last = row_last && (row_ff >= last_row);

   always_comb begin
      if (image_last) begin
         col_in = '0;
         row_in = '0;
      end else if (row_last) begin
         col_in = '0;
         row_in = row_ff + HEIGHT_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
         row_in = row_ff;
      end
   end

   assign rd_addr = acc ? col_in : col_ff;

   always_comb begin
      ctl.mode = mode_ff;
      if (row_ff == '0 && col_ff == '0) begin
         ctl.pos = POS_FIRST;
      end else if (row_ff == '0) begin
         ctl.pos = POS_FIRST_ROW;
      end else if (col_ff == '0) begin
         ctl.pos = POS_FIRST_COL;
      end else begin
         ctl.pos = POS_INTERIOR;
      end
   end

   lpp_line_buf u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (acc),
      .wr_addr (col_ff),
      .wr_data (pixel),
      .rd_addr (rd_addr),
      .rd_data (above)
   );

   lpp_lane u_lane_luma (
      .left       (left_ff[7:0]),
      .above      (above[7:0]),
      .upper_left (upl_ff[7:0]),
      .residual   (req_residual_luma),
      .ctl        (ctl),
      .pixel      (pixel[7:0])
   );

   lpp_lane u_lane_blue (
      .left       (left_ff[15:8]),
      .above      (above[15:8]),
      .upper_left (upl_ff[15:8]),
      .residual   (req_residual_blue_diff),
      .ctl        (ctl),
      .pixel      (pixel[15:8])
   );

   lpp_lane u_lane_red (
      .left       (left_ff[23:16]),
      .above      (above[23:16]),
      .upper_left (upl_ff[23:16]),
      .residual   (req_residual_red_diff),
      .ctl        (ctl),
      .pixel      (pixel[23:16])
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
         upl_ff  <= '0;
      end else if (acc) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         left_ff <= pixel;
         upl_ff  <= above;
      end
   end

   assign item.luma      = pixel[7:0];
   assign item.blue_diff = pixel[15:8];
   assign item.red_diff  = pixel[23:16];
   assign item.row_end   = row_last;
   assign item.image_end = image_last;

   out_item_type rsp_item;

   lpp_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_item   (item),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_item  (rsp_item),
      .out_stall (rsp_stall)
   );

   assign rsp_pixel_luma      = rsp_item.luma;
   assign rsp_pixel_blue_diff = rsp_item.blue_diff;
   assign rsp_pixel_red_diff  = rsp_item.red_diff;
   assign rsp_row_end         = rsp_item.row_end;
   assign rsp_image_end       = rsp_item.image_end;

   assert property (@(posedge clock) disable iff (reset)
      (acc && row_last) |=> col_ff == '0)
      else $error("column not cleared after row end");

   assert property (@(posedge clock) disable iff (reset)
      !acc |=> $stable(col_ff) && $stable(row_ff) && $stable(left_ff))
      else $error("position or neighbor moved without a transaction");

   assert property (@(posedge clock) disable iff (reset)
      (acc && image_last) |=> (row_ff == '0) && (col_ff == '0))
      else $error("counters not cleared after image end");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_end) |-> rsp_row_end)
      else $error("image end without row end");

endmodule

// File: rtl/lpp_lane.sv
module lpp_lane
   import lpp_pkg::*;
(
   input  logic [7:0]        left,
   input  logic [7:0]        above,
   input  logic [7:0]        upper_left,
   input  logic signed [8:0] residual,
   input  lane_ctl_type      ctl,
   output logic [7:0]        pixel
);

   logic signed [10:0] sa, sb, sc;
   logic [9:0]         sum3;
   logic [8:0]         sum2;
   logic [19:0]        prod3;
   logic signed [10:0] diff_bc, diff_ac, adj_bc, adj_ac, half_bc, half_ac;
   logic [7:0]         lo, hi;
   logic signed [10:0] planar, med, pred_mode, pred, total;

   assign sa = $signed({3'b000, left});
   assign sb = $signed({3'b000, above});
   assign sc = $signed({3'b000, upper_left});

   assign sum3  = 10'(left) + 10'(above) + 10'(upper_left);
   assign sum2  = 9'(left) + 9'(above);
   assign prod3 = 20'(sum3) * RECIP3;

   assign diff_bc = sb - sc;
   assign diff_ac = sa - sc;
   assign adj_bc  = diff_bc + $signed({10'b0, diff_bc[10]});
   assign adj_ac  = diff_ac + $signed({10'b0, diff_ac[10]});
   assign half_bc = adj_bc >>> 1;
   assign half_ac = adj_ac >>> 1;

   assign planar = sa + sb - sc;
   assign lo     = (left < above) ? left : above;
   assign hi     = (left < above) ? above : left;

   always_comb begin
      if (upper_left >= hi) begin
         med = $signed({3'b000, lo});
      end else if (upper_left <= lo) begin
         med = $signed({3'b000, hi});
      end else begin
         med = planar;
      end
   end

   always_comb begin
      case (ctl.mode)
         MODE_MEAN3:   pred_mode = $signed({3'b000, prod3[RECIP3_SH+7:RECIP3_SH]});
         MODE_LEFT:    pred_mode = sa;
         MODE_ABOVE:   pred_mode = sb;
         MODE_UPLEFT:  pred_mode = sc;
         MODE_PLANAR:  pred_mode = planar;
         MODE_HALF_BC: pred_mode = sa + half_bc;
         MODE_HALF_AC: pred_mode = sb + half_ac;
         MODE_MEAN2:   pred_mode = $signed({3'b000, sum2[8:1]});
         MODE_MED:     pred_mode = med;
         default:      pred_mode = '0;
      endcase
   end

   always_comb begin
      unique case (ctl.pos)
         POS_FIRST:     pred = '0;
         POS_FIRST_ROW: pred = sa;
         POS_FIRST_COL: pred = sb;
         POS_INTERIOR:  pred = pred_mode;
      endcase
   end

   assign total = pred + 11'(residual);
   assign pixel = total[7:0];

endmodule

// File: rtl/lpp_line_buf.sv
module lpp_line_buf
   import lpp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic [COL_W-1:0] rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [MAX_WIDTH];
   logic [PIX_W-1:0] rd_ff;
   logic [PIX_W-1:0] byp_data_ff;
   logic             byp_ff;
   logic             byp_in;

   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff       <= mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

// File: rtl/lpp_out_skid.sv
module lpp_out_skid
   import lpp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  out_item_type in_item,
   output logic         in_stall,
   output logic         out_valid,
   output out_item_type out_item,
   input  logic         out_stall
);

   logic         out_valid_ff, skid_valid_ff;
   out_item_type out_item_ff, skid_item_ff;
   logic         acc, take;

   assign in_stall  = skid_valid_ff;
   assign acc       = in_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !out_stall;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            out_item_ff   <= skid_item_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= acc;
            if (acc) begin
               out_item_ff <= in_item;
            end
         end
      end else if (acc) begin
         if (!out_valid_ff) begin
            out_item_ff  <= in_item;
            out_valid_ff <= 1'b1;
         end else begin
            skid_item_ff  <= in_item;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while output is empty");

   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_stall) |=> skid_valid_ff && $stable(skid_item_ff))
      else $error("skid transaction lost under stall");

   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> out_item_ff == $past(skid_item_ff))
      else $error("skid transaction not promoted to output");

endmodule

// File: verif/tb.sv
module tb;
   import lpp_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_PIXELS = 620;
   localparam int MEAN_DIV      = 3;

   class recon_scoreboard;
      logic [PIX_W-1:0]    line_mem [MAX_WIDTH];
      logic [PIX_W-1:0]    left_px;
      logic [PIX_W-1:0]    upleft_px;
      int                  col;
      int                  row;
      logic [MODE_W-1:0]   mode;
      logic [WIDTH_W-1:0]  width_reg;
      logic [HEIGHT_W-1:0] height_reg;
      out_item_type        pending_pixels [$];
      int                  errors;

      function new();
         for (int i = 0; i < MAX_WIDTH; i++) line_mem[i] = '0;
         left_px    = '0;
         upleft_px  = '0;
         col        = 0;
         row        = 0;
         mode       = MODE_MEAN3;
         width_reg  = WIDTH_W'(MAX_WIDTH);
         height_reg = HEIGHT_W'(1);
         errors     = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_MODE:   mode = data[MODE_W-1:0];
            CSR_WIDTH:  width_reg = data[WIDTH_W-1:0];
            CSR_HEIGHT: height_reg = data[HEIGHT_W-1:0];
            default: ;
         endcase
      endfunction

      function int eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return int'(width_reg);
      endfunction

      function bit at_frame_start();
         return col == 0 && row == 0;
      endfunction

      function int predict_channel(input int a, input int b, input int c);
         int lo;
         int hi;
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         case (mode)
            MODE_MEAN3:   return (a + b + c) / MEAN_DIV;
            MODE_LEFT:    return a;
            MODE_ABOVE:   return b;
            MODE_UPLEFT:  return c;
            MODE_PLANAR:  return a + b - c;
            MODE_HALF_BC: return a + (b - c) / 2;
            MODE_HALF_AC: return b + (a - c) / 2;
            MODE_MEAN2:   return (a + b) / 2;
            MODE_MED: begin
               if (c >= hi) return lo;
               if (c <= lo) return hi;
               return a + b - c;
            end
            default: return 0;
         endcase
      endfunction

      function void note_residual(input logic signed [8:0] y,
                                  input logic signed [8:0] cb,
                                  input logic signed [8:0] cr);
         logic signed [8:0] res [3];
         logic [PIX_W-1:0]  above;
         logic [PIX_W-1:0]  px;
         out_item_type      item;
         int                w;
         int                h;
         int                ci;
         int                pred;
         res[0] = y;
         res[1] = cb;
         res[2] = cr;
         w  = eff_width();
         h  = (height_reg == 0) ? 1 : int'(height_reg);
         ci = (col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col;
         above = line_mem[ci];
         px = '0;
         for (int k = 0; k < 3; k++) begin
            if (row == 0 && ci == 0) begin
               pred = 0;
            end else if (row == 0) begin
               pred = int'(left_px[8*k +: 8]);
            end else if (ci == 0) begin
               pred = int'(above[8*k +: 8]);
            end else begin
               pred = predict_channel(int'(left_px[8*k +: 8]), int'(above[8*k +: 8]),
                                      int'(upleft_px[8*k +: 8]));
            end
            px[8*k +: 8] = 8'(pred + int'(res[k]));
         end
         line_mem[ci] = px;
         left_px   = px;
         upleft_px = above;
         item.luma      = px[7:0];
         item.blue_diff = px[15:8];
         item.red_diff  = px[23:16];
         item.row_end   = (ci >= w - 1);
         item.image_end = item.row_end && (row >= h - 1);
         if (item.image_end) begin
            col = 0;
            row = 0;
         end else if (item.row_end) begin
            col = 0;
            row = row + 1;
         end else begin
            col = ci + 1;
         end
         pending_pixels.insert(pending_pixels.size(), item);
      endfunction

      function void check_field(input string name, input int exp_v, input int act_v);
         if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_pixel(input logic [7:0] y, input logic [7:0] cb,
                                input logic [7:0] cr, input logic row_end,
                                input logic image_end);
         out_item_type exp_px;
         if (pending_pixels.size() == 0) begin
            $error("pixel transaction with none pending: luma %0d", y);
            errors++;
            return;
         end
         exp_px = pending_pixels.pop_front();
         check_field("pixel_luma", exp_px.luma, y);
         check_field("pixel_blue_diff", exp_px.blue_diff, cb);
         check_field("pixel_red_diff", exp_px.red_diff, cr);
         check_field("row_end", exp_px.row_end, row_end);
         check_field("image_end", exp_px.image_end, image_end);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [8:0]    req_residual_luma = '0;
   logic signed [8:0]    req_residual_blue_diff = '0;
   logic signed [8:0]    req_residual_red_diff = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_pixel_luma;
   logic [7:0]           rsp_pixel_blue_diff;
   logic [7:0]           rsp_pixel_red_diff;
   logic                 rsp_row_end;
   logic                 rsp_image_end;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   recon_scoreboard sb;
   int  idle_cycles = 0;
   int  pixels_sent = 0;
   int  burst_left = 0;
   int  gap_max = 0;
   bit  stall_en = 1'b0;
   int  stall_max = 4;
   int  stall_run = 0;
   bit  stall_on = 1'b0;

   lossless_pixel_prediction_reconstruct u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_residual_luma      (req_residual_luma),
      .req_residual_blue_diff (req_residual_blue_diff),
      .req_residual_red_diff  (req_residual_red_diff),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_pixel_luma         (rsp_pixel_luma),
      .rsp_pixel_blue_diff    (rsp_pixel_blue_diff),
      .rsp_pixel_red_diff     (rsp_pixel_red_diff),
      .rsp_row_end            (rsp_row_end),
      .rsp_image_end          (rsp_image_end),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_on  = !stall_on;
         stall_run = stall_on ? $urandom_range(1, stall_max) : $urandom_range(1, 3 * stall_max);
      end
      stall_run--;
      rsp_stall <= stall_en && stall_on;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_pixel(rsp_pixel_luma, rsp_pixel_blue_diff, rsp_pixel_red_diff,
                           rsp_row_end, rsp_image_end);
         end
         if (req_valid && !req_stall) begin
            sb.note_residual(req_residual_luma, req_residual_blue_diff,
                             req_residual_red_diff);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("lossless_pixel_prediction_reconstruct test failed");
      $finish;
   end

   function automatic int rand_residual();
      int v;
      case ($urandom_range(0, 3))
         0: v = int'($urandom_range(0, 16)) - 8;
         1: begin
            case ($urandom_range(0, 3))
               0: v = -256;
               1: v = 255;
               2: v = -1;
               default: v = 0;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_pixel(input int y, input int cb, input int cr);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid              <= 1'b1;
      req_residual_luma      <= y[8:0];
      req_residual_blue_diff <= cb[8:0];
      req_residual_red_diff  <= cr[8:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input int data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DAT_W-1:0];
      sb.write_reg(idx, data[CSR_DAT_W-1:0]);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input int mode, input int width, input int height);
      set_reg(CSR_MODE, mode);
      set_reg(CSR_WIDTH, width);
      set_reg(CSR_HEIGHT, height);
   endtask

   task automatic send_image();
      do begin
         send_pixel(rand_residual(), rand_residual(), rand_residual());
         if (!sb.at_frame_start() && $urandom_range(0, 47) == 0) begin
            pause_until_drained();
            case ($urandom_range(0, 2))
               0: set_reg(CSR_MODE, $urandom_range(0, (1 << MODE_W) - 1));
               1: set_reg(CSR_WIDTH, $urandom_range(1, sb.eff_width()));
               default: set_reg(CSR_HEIGHT, $urandom_range(1, 8));
            endcase
         end
      end while (!sb.at_frame_start());
   endtask

   initial begin
      int base;
      int phase;
      int sel;
      int width;
      int height;
      sb = new();
      gap_max  = 3;
      stall_en = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults, then shrink the width under the current column
      send_pixel(255, -256, 0);
      send_pixel(-256, 255, -1);
      send_pixel(1, -1, 127);
      pause_until_drained();
      set_reg(CSR_WIDTH, 2);
      send_pixel(0, 0, 0);
      pause_until_drained();

      // zero width and height both act as one
      configure(MODE_MEAN3, 0, 0);
      send_pixel(-256, 255, 1);
      send_pixel(255, -256, -1);
      pause_until_drained();

      // one interior pixel per row for every mode, then shrink the height
      configure(MODE_MEAN3, 2, (1 << HEIGHT_W) - 1);
      send_pixel(255, 128, -256);
      send_pixel(-1, 255, 17);
      for (int m = 0; m < (1 << MODE_W); m++) begin
         if (m <= MODE_MED + 1 || m == (1 << MODE_W) - 1) begin
            pause_until_drained();
            set_reg(CSR_MODE, m);
            send_pixel(rand_residual(), rand_residual(), rand_residual());
            send_pixel(rand_residual(), rand_residual(), rand_residual());
         end
      end
      pause_until_drained();
      set_reg(CSR_HEIGHT, 3);
      send_pixel(rand_residual(), rand_residual(), rand_residual());
      send_pixel(rand_residual(), rand_residual(), rand_residual());
      pause_until_drained();

      base  = pixels_sent;
      phase = 0;
      while (pixels_sent - base < RANDOM_PIXELS) begin
         pause_until_drained();
         if (phase % 4 == 0) begin
            gap_max  = 0;
            stall_en = 1'b0;
         end else begin
            gap_max   = $urandom_range(1, 12);
            stall_en  = $urandom_range(0, 3) != 0;
            stall_max = $urandom_range(1, 8);
         end
         sel = $urandom_range(0, 9);
         if (sel == 0) width = 0;
         else if (sel <= 6) width = $urandom_range(1, 8);
         else if (sel <= 8) width = $urandom_range(9, 40);
         else width = $urandom_range(41, 160);
         height = (width > 40) ? $urandom_range(1, 2) : $urandom_range(0, 6);
         configure(($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << MODE_W) - 1)
                                               : $urandom_range(0, MODE_MED),
                   width, height);
         repeat ($urandom_range(1, 3)) send_image();
         phase++;
      end

      // width above the line memory, then shrink it under the current column
      pause_until_drained();
      gap_max   = 4;
      stall_en  = 1'b1;
      stall_max = 3;
      configure($urandom_range(0, MODE_MED), MAX_WIDTH + 476, 2);
      repeat (6) send_pixel(rand_residual(), rand_residual(), rand_residual());
      pause_until_drained();
      set_reg(CSR_WIDTH, 3);
      send_image();

      pause_until_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("lossless_pixel_prediction_reconstruct test passed");
      end else begin
         $display("lossless_pixel_prediction_reconstruct test failed");
      end
      $finish;
   end

endmodule
